>>> hw/rtl/led_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_pkg
// Shared types, codes and helpers of the escape decoder.
// ----------------------------------------------------------------------------
package led_pkg;

	// decoder modes
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_ESCAPE  = 3'd1,
		MODE_DECIMAL = 3'd2,
		MODE_ZSKIP   = 3'd3,
		MODE_DROP    = 3'd4
	} mode_t;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_BADESC = 2'd2;

	localparam logic [1:0] DEC_MAX_DIGITS = 2'd3;
	localparam logic [9:0] BYTE_MAX       = 10'h0FF;
	localparam logic [7:0] CH_BSLASH      = 8'h5C;

	// result FIFO depth (power of two)
	localparam int unsigned RES_DEPTH = 4;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [1:0] status;
		logic       run_last;
		logic       string_end;
	} result_t;

	function automatic result_t mk_res(input logic [7:0] b, input logic v,
			input logic [1:0] st);
		result_t r;
		r.out_byte   = b;
		r.byte_valid = v;
		r.status     = st;
		r.run_last   = 1'b0;
		r.string_end = 1'b0;
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

endpackage : led_pkg
`default_nettype wire

>>> hw/rtl/led_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_in_if / led_out_if
// Valid/ready channels for raw bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface led_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface : led_in_if

interface led_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [1:0] status;
	logic       run_last;
	logic       string_end;

	modport source (output valid, output out_byte, output byte_valid, output status,
		output run_last, output string_end, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input status,
		input run_last, input string_end, output ready);
endinterface : led_out_if
`default_nettype wire

>>> hw/rtl/lua_escape_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lua_escape_decoder_unit
// Decodes string literal bodies byte by byte; each accepted byte yields zero,
// one or two result beats queued in a four-entry result FIFO.
// Results are written into the result FIFO and read out from its head.
// Throughput: one input beat per cycle while the FIFO has two free entries; output
// drains one beat per cycle while ready, so two-result bytes set the sustained limit.
// Reset: arst_n clears the decode state and empties the result FIFO.
// ----------------------------------------------------------------------------
module lua_escape_decoder_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	led_in_if.sink    in_ch,
	led_out_if.source out_ch
);
	import led_pkg::*;

	localparam int unsigned PW = $clog2(RES_DEPTH);

	mode_t       mode_q, mode_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [9:0]  acc_q, acc_n;

	result_t     res [2];
	logic [1:0]  n_res;

	result_t     fifo_q [RES_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   count_q;

	logic        in_acc, out_acc;
	logic [7:0]  b;
	logic        eos;
	logic [13:0] acc_mul;
	logic        dec_close;

	assign b   = in_ch.in_byte;
	assign eos = in_ch.end_of_string;

	// decode step for the byte on the input channel
	always_comb begin
		mode_n    = mode_q;
		cnt_n     = cnt_q;
		acc_n     = acc_q;
		n_res     = 2'd0;
		res[0]    = mk_res(8'h00, 1'b0, ST_OK);
		res[1]    = mk_res(8'h00, 1'b0, ST_OK);
		acc_mul   = {4'd0, acc_q} * 14'd10 + {10'd0, b[3:0]};
		dec_close = 1'b0;

		unique case (mode_q)
			MODE_ESCAPE: begin
				mode_n = MODE_NORMAL;
				if (is_digit(b)) begin
					acc_n  = {6'd0, b[3:0]};
					cnt_n  = 2'd1;
					mode_n = MODE_DECIMAL;
				end else begin
					n_res = 2'd1;
					case (b)
						8'h61: res[0] = mk_res(8'h07, 1'b1, ST_OK);
						8'h62: res[0] = mk_res(8'h08, 1'b1, ST_OK);
						8'h66: res[0] = mk_res(8'h0C, 1'b1, ST_OK);
						8'h6E: res[0] = mk_res(8'h0A, 1'b1, ST_OK);
						8'h72: res[0] = mk_res(8'h0D, 1'b1, ST_OK);
						8'h74: res[0] = mk_res(8'h09, 1'b1, ST_OK);
						8'h76: res[0] = mk_res(8'h0B, 1'b1, ST_OK);
						8'h5C, 8'h22, 8'h27: res[0] = mk_res(b, 1'b1, ST_OK);
						8'h7A: begin
							n_res  = 2'd0;
							mode_n = MODE_ZSKIP;
						end
						default: begin
							res[0] = mk_res(8'h00, 1'b0, ST_BADESC);
							mode_n = MODE_DROP;
						end
					endcase
				end
			end
			MODE_DECIMAL: begin
				if (is_digit(b)) begin
					acc_n = acc_mul[9:0];
					cnt_n = cnt_q + 2'd1;
					if (cnt_n >= DEC_MAX_DIGITS) dec_close = 1'b1;
				end else begin
					dec_close = 1'b1;
				end
				if (dec_close) begin
					n_res = 2'd1;
					if (acc_n > BYTE_MAX) begin
						res[0] = mk_res(8'h00, 1'b0, ST_RANGE);
						mode_n = MODE_DROP;
					end else begin
						res[0] = mk_res(acc_n[7:0], 1'b1, ST_OK);
						mode_n = MODE_NORMAL;
						// closing non-digit is decoded as a plain byte, or a backslash opens an escape
						if (!is_digit(b)) begin
							if (b == CH_BSLASH) mode_n = MODE_ESCAPE;
							else begin
								res[1] = mk_res(b, 1'b1, ST_OK);
								n_res  = 2'd2;
							end
						end
					end
					acc_n = 10'd0;
					cnt_n = 2'd0;
				end
			end
			MODE_ZSKIP: begin
				if (!is_space(b)) begin
					mode_n = MODE_NORMAL;
					if (b == CH_BSLASH) mode_n = MODE_ESCAPE;
					else begin
						res[0] = mk_res(b, 1'b1, ST_OK);
						n_res  = 2'd1;
					end
				end
			end
			MODE_DROP: begin
			end
			default: begin
				mode_n = MODE_NORMAL;
				if (b == CH_BSLASH) mode_n = MODE_ESCAPE;
				else begin
					res[0] = mk_res(b, 1'b1, ST_OK);
					n_res  = 2'd1;
				end
			end
		endcase

		// end of string: flush an open decimal, then mark the last beat
		if (eos) begin
			if (mode_n == MODE_DECIMAL) begin
				if (acc_n > BYTE_MAX) res[n_res[0]] = mk_res(8'h00, 1'b0, ST_RANGE);
				else                  res[n_res[0]] = mk_res(acc_n[7:0], 1'b1, ST_OK);
				n_res = n_res + 2'd1;
			end
			if (n_res == 2'd0) n_res = 2'd1;
			res[~n_res[0]].string_end = 1'b1;
			mode_n = MODE_NORMAL;
			cnt_n  = 2'd0;
			acc_n  = 10'd0;
		end
		if (n_res != 2'd0) res[~n_res[0]].run_last = 1'b1;
	end

	// handshakes
	assign in_ch.ready  = (count_q <= (PW+1)'(RES_DEPTH - 2));
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (count_q != '0);
	assign out_acc      = out_ch.valid && out_ch.ready;

	assign out_ch.out_byte   = fifo_q[rd_q].out_byte;
	assign out_ch.byte_valid = fifo_q[rd_q].byte_valid;
	assign out_ch.status     = fifo_q[rd_q].status;
	assign out_ch.run_last   = fifo_q[rd_q].run_last;
	assign out_ch.string_end = fifo_q[rd_q].string_end;

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			cnt_q  <= 2'd0;
			acc_q  <= 10'd0;
		end else if (in_acc) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
			acc_q  <= acc_n;
		end
	end

	// result FIFO pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (in_acc) wr_q <= wr_q + PW'(n_res);
			if (out_acc) rd_q <= rd_q + PW'(1);
			count_q <= count_q + (in_acc ? (PW+1)'(n_res) : '0)
				- (out_acc ? (PW+1)'(1) : '0);
		end
	end

	// result FIFO storage
	always_ff @(posedge clk) begin
		if (in_acc && (n_res != 2'd0)) fifo_q[wr_q] <= res[0];
		if (in_acc && (n_res == 2'd2)) fifo_q[wr_q + PW'(1)] <= res[1];
	end

endmodule : lua_escape_decoder_unit
`default_nettype wire
